@@ hdl/kmp_pkg.sv @@
// kmp_pkg: shared types, sizes and codes for the kmp stream matcher
// used by kmp_ctrl, kmp_dpath and kmp_stream_matcher; no dependencies
package kmp_pkg;

	localparam int MAX_PATTERN   = 64;
	localparam int POSITION_BITS = 32;

	// index into the pattern store, and a length that can reach MAX_PATTERN
	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	localparam int SYM_W    = 8;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int ENDPOS_W = 32;

	// stream word widths, padded to whole bytes
	localparam int S_DATA_W = ((CMD_W + SYM_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((1 + ENDPOS_W + STAT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_TEXT    = 2'd3
	} kmp_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NO_PAT = 2'd2,
		ST_SAT    = 2'd3
	} kmp_status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_RUN
	} kmp_fsm_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // take the input word, start the first store read
		logic iter;    // one fallback step through the failure table
		logic commit;  // update state and capture the result word
	} kmp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic done;    // search has settled, result is ready to commit
	} kmp_stat_t;

endpackage

@@ hdl/kmp_ctrl.sv @@
// kmp_ctrl: controller state machine for the kmp stream matcher
// depends on kmp_pkg; drives kmp_dpath through kmp_ctl_t
module kmp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  kmp_pkg::kmp_stat_t stat,
	output kmp_pkg::kmp_ctl_t  ctl
);
	import kmp_pkg::*;

	kmp_fsm_t state_q, state_d;
	logic     out_valid_q;
	logic     out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ctl        = '0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = FSM_RUN;
				end
			end
			FSM_RUN: begin
				if (!stat.done) begin
					ctl.iter = 1'b1;
				end else if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/kmp_dpath.sv @@
// kmp_dpath: pattern store, failure table, match state and result register
// depends on kmp_pkg; sequenced by kmp_ctrl
module kmp_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kmp_pkg::kmp_ctl_t            ctl,
	output kmp_pkg::kmp_stat_t           stat,
	input  kmp_pkg::kmp_cmd_t            in_cmd,
	input  logic [kmp_pkg::SYM_W-1:0]    in_sym,
	output logic                         match_found,
	output logic [kmp_pkg::ENDPOS_W-1:0] end_position,
	output kmp_pkg::kmp_status_t         status
);
	import kmp_pkg::*;

	// memories, no reset: only entries below the pattern length are read
	logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
	logic [IDX_W-1:0] fail_mem [MAX_PATTERN];
	logic [SYM_W-1:0] pat_rd_q;
	logic [IDX_W-1:0] fail_rd_q;

	// architectural state
	logic [LEN_W-1:0]         pat_len_q;
	logic [IDX_W-1:0]         pre_len_q;
	logic [LEN_W-1:0]         mat_len_q;
	logic [POSITION_BITS-1:0] pos_q;

	// item being worked on
	kmp_cmd_t         cmd_q;
	logic [SYM_W-1:0] sym_q;
	logic [LEN_W-1:0] j_q;

	// result word
	logic                found_q;
	logic [ENDPOS_W-1:0] endpos_q;
	kmp_status_t         status_q;

	logic                     full, sat, searching, step_more;
	logic [LEN_W-1:0]         start_j, next_j, rd_j, final_j;
	logic [IDX_W-1:0]         rd_idx, wr_idx;
	logic                     wr_en;
	logic [LEN_W-1:0]         pat_len_d, mat_len_d;
	logic [IDX_W-1:0]         pre_len_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic                     found_d;
	kmp_status_t              status_d;

	assign full = (pat_len_q == LEN_W'(MAX_PATTERN));
	assign sat  = &pos_q;

	assign searching = ((cmd_q == CMD_APPEND) && !full && (pat_len_q != '0))
	                || ((cmd_q == CMD_TEXT) && (pat_len_q != '0) && !sat);

	// fall back while the current prefix cannot be extended
	assign step_more = searching && (j_q != '0) && (pat_rd_q != sym_q);
	assign stat.done = !step_more;
	assign next_j    = LEN_W'(fail_rd_q);
	assign final_j   = (pat_rd_q == sym_q) ? j_q + LEN_W'(1) : j_q;

	assign start_j = (in_cmd == CMD_APPEND) ? LEN_W'(pre_len_q) : mat_len_q;

	always_comb begin
		if (ctl.load)
			rd_j = start_j;
		else if (ctl.iter)
			rd_j = next_j;
		else
			rd_j = j_q;
	end
	assign rd_idx = rd_j[IDX_W-1:0];
	assign wr_idx = pat_len_q[IDX_W-1:0];

	// state update for the commit
	always_comb begin
		pat_len_d = pat_len_q;
		pre_len_d = pre_len_q;
		mat_len_d = mat_len_q;
		pos_d     = pos_q;
		found_d   = 1'b0;
		status_d  = ST_OK;
		wr_en     = 1'b0;
		case (cmd_q)
			CMD_CLEAR: begin
				pat_len_d = '0;
				pre_len_d = '0;
				mat_len_d = '0;
			end
			CMD_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					pat_len_d = pat_len_q + LEN_W'(1);
					if (pat_len_q == '0)
						pre_len_d = '0;
					else
						pre_len_d = final_j[IDX_W-1:0];
				end
			end
			CMD_RESTART: begin
				mat_len_d = '0;
				pos_d     = '0;
			end
			CMD_TEXT: begin
				if (pat_len_q == '0) begin
					status_d = ST_NO_PAT;
				end else if (sat) begin
					status_d = ST_SAT;
				end else begin
					pos_d = pos_q + POSITION_BITS'(1);
					if (final_j >= pat_len_q) begin
						// overlapping matches: resume from the last failure entry
						found_d   = 1'b1;
						mat_len_d = LEN_W'(pre_len_q);
					end else begin
						mat_len_d = final_j;
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pat_rd_q  <= pat_mem[rd_idx];
		fail_rd_q <= fail_mem[rd_idx - IDX_W'(1)];
		if (ctl.commit && wr_en) begin
			pat_mem[wr_idx]  <= sym_q;
			fail_mem[wr_idx] <= pre_len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_cmd;
			sym_q <= in_sym;
		end
		if (ctl.load || ctl.iter)
			j_q <= rd_j;
		if (ctl.commit) begin
			found_q  <= found_d;
			endpos_q <= ENDPOS_W'(pos_d);
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			pre_len_q <= '0;
			mat_len_q <= '0;
			pos_q     <= '0;
		end else if (ctl.commit) begin
			pat_len_q <= pat_len_d;
			pre_len_q <= pre_len_d;
			mat_len_q <= mat_len_d;
			pos_q     <= pos_d;
		end
	end

	assign match_found  = found_q;
	assign end_position = endpos_q;
	assign status       = status_q;

endmodule

@@ hdl/kmp_stream_matcher.sv @@
// kmp_stream_matcher: top level of the knuth-morris-pratt byte stream matcher
// depends on kmp_pkg, kmp_ctrl and kmp_dpath
//
// channel  dir  word bits                                    handshake
// s_*      in   [1:0] command, [9:2] symbol                  s_tvalid / s_tready
// m_*      out  [0] match_found, [32:1] end_position,        m_tvalid / m_tready
//               [34:33] status
//
// every word is accepted, then takes one fallback step through the failure
// table per mismatch before it is evaluated and committed; the fallback loop is
// bound by the registered read of the pattern store and failure table
// a word is accepted only while the controller is idle; one result word
// is produced per input word and held in the output register until taken
// a held result stalls the commit of the next word, not its acceptance
// reset clears lengths and text position; the stores need no clearing pass
module kmp_stream_matcher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [kmp_pkg::S_DATA_W-1:0] s_tdata,   // command, symbol, zero pad
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [kmp_pkg::M_DATA_W-1:0] m_tdata    // match_found, end_position,
	                                                // status, zero pad
);
	import kmp_pkg::*;

	kmp_ctl_t            ctl;
	kmp_stat_t           stat;
	logic                match_found;
	logic [ENDPOS_W-1:0] end_position;
	kmp_status_t         status;

	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	kmp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.in_cmd       (kmp_cmd_t'(s_tdata[CMD_W-1:0])),
		.in_sym       (s_tdata[CMD_W+SYM_W-1:CMD_W]),
		.match_found  (match_found),
		.end_position (end_position),
		.status       (status)
	);

	// pack the result word, lowest field first
	assign m_tdata = M_DATA_W'({status, end_position, match_found});

endmodule
